@@ hdl/cru_pkg.sv @@
// Shared types, constants and arithmetic helpers for the Cholesky rank-one update unit.
`default_nettype none
package cru_pkg;

    localparam int DW       = 32;
    localparam int FRAC     = 16;
    localparam int ORDER    = 16;
    localparam int NUM_W    = DW + FRAC;

    localparam logic [5:0] MUL_LAST  = 6'd31;
    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST  = 6'd47;

    localparam logic signed [DW-1:0] ONE_Q    = 32'sd65536;
    localparam logic signed [DW-1:0] SAT_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] SAT_MIN  = 32'sh8000_0000;
    localparam logic [79:0]          MAG_CAP  = 80'h4000_0000_0000_0001;
    localparam logic [4:0]           COL_MAX  = 5'd16;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_MUL_LOAD = 9'b000000010,
        S_MUL_RUN  = 9'b000000100,
        S_MUL_DONE = 9'b000001000,
        S_SQRT     = 9'b000010000,
        S_ROOT     = 9'b000100000,
        S_DIV_RUN  = 9'b001000000,
        S_DIV_DONE = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        OP_SX = 3'd0,
        OP_CR = 3'd1,
        OP_SG = 3'd2,
        OP_CX = 3'd3,
        OP_SR = 3'd4,
        OP_RR = 3'd5,
        OP_XX = 3'd6,
        OP_XA = 3'd7
    } op_t;

    function automatic logic [DW-1:0] mag32(input logic signed [DW-1:0] v);
        mag32 = v[DW-1] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic signed [DW-1:0] sat64(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF)
            sat64 = SAT_MAX;
        else if (v < -64'sh0000_0000_8000_0000)
            sat64 = SAT_MIN;
        else
            sat64 = v[DW-1:0];
    endfunction

    // Applies the quotient sign, truncating toward zero, then saturates.
    function automatic logic signed [DW-1:0] qsat(input logic [NUM_W-1:0] q, input logic neg);
        if (!neg)
            qsat = (q > 48'h0000_7FFF_FFFF) ? SAT_MAX : q[DW-1:0];
        else
            qsat = (q > 48'h0000_8000_0000) ? SAT_MIN : (~q[DW-1:0] + 32'd1);
    endfunction

endpackage
`default_nettype wire

@@ hdl/cholesky_rank_one_update_downdate_unit.sv @@
// Top level of the bit-serial Cholesky rank-one update and downdate unit.
// Entries of R arrive column by column with the x element of their column; each request
// gives one result. A pass-through entry, or a diagonal with zero x, goes straight to the
// done state. An off-diagonal entry runs five 32-step shift-add multiplies on the one
// shared serial multiplier. A diagonal entry runs three multiplies, a 32-step square root
// (two radicand bits a cycle) and two 48-step restoring divisions. One request is in work
// at a time; the finished result sits in an output register so the next request can start
// while it waits. The rotation tables need no clearing: a row is always written by its
// diagonal before it is read.
`default_nettype none
module cholesky_rank_one_update_downdate_unit
    import cru_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic signed [31:0] cfg_wdata,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic signed [31:0] r_value,
    input  wire logic signed [31:0] x_value,
    input  wire logic [3:0]         row_index,
    input  wire logic               is_diagonal,
    input  wire logic               last_column,
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      logic signed [31:0] r_out,
    output      logic [3:0]         row_out,
    output      logic               status,
    output      logic [4:0]         fail_column,
    output      logic               end_of_update
);

    state_t state_reg;
    op_t    op_reg;
    logic [5:0] cnt_reg;

    logic signed [DW-1:0] sigma_reg, running_x_reg;
    logic                 failed_reg;
    logic [4:0]           fcol_reg, ccount_reg;

    logic signed [DW-1:0] r_reg, c_reg, s_reg, sx_reg, res_reg, cosv_reg;
    logic [3:0]           row_reg;
    logic                 diag_reg, last_reg;
    logic signed [NUM_W-1:0] t_reg;
    logic [63:0]          r2_reg, x2_reg;

    logic [63:0]  mhi_reg, mcand_reg;
    logic [31:0]  mlo_reg;
    logic         mneg_reg;

    logic [63:0]  srad_reg;
    logic [33:0]  srem_reg;
    logic [31:0]  sroot_reg;

    logic [NUM_W-1:0] dq_reg;
    logic [DW-1:0]    drem_reg, dden_reg;
    logic             dneg_reg, dsel_reg;

    logic               ovalid_reg, oend_reg, ostat_reg;
    logic signed [31:0] or_reg;
    logic [3:0]         orow_reg;
    logic [4:0]         ofcol_reg;

    logic signed [DW-1:0] cos_mem [ORDER];
    logic signed [DW-1:0] sin_mem [ORDER];

    logic accept, out_free, tbl_we;
    logic [3:0] tbl_addr;
    logic signed [DW-1:0] tbl_cos, tbl_sin, x_now, mul_a, mul_b, sin_q;
    logic [64:0] msum;
    logic [95:0] prod;
    logic signed [63:0] p64, t64, psh64;
    logic [63:0] mag, rad;
    logic [33:0] rem2, trial;
    logic [DW-1:0] dtr;
    logic [DW-1:0] root_sat;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !ovalid_reg || !out_stall;
    assign x_now    = (row_index == 4'd0) ? x_value : running_x_reg;

    always_comb
    begin
        unique case (op_reg)
            OP_SX:   begin mul_a = s_reg;     mul_b = running_x_reg; end
            OP_CR:   begin mul_a = c_reg;     mul_b = r_reg;         end
            OP_SG:   begin mul_a = sigma_reg; mul_b = sx_reg;        end
            OP_CX:   begin mul_a = c_reg;     mul_b = running_x_reg; end
            OP_SR:   begin mul_a = s_reg;     mul_b = r_reg;         end
            OP_RR:   begin mul_a = r_reg;     mul_b = r_reg;         end
            default: begin mul_a = running_x_reg; mul_b = running_x_reg; end
        endcase
    end

    assign msum  = {1'b0, mhi_reg} + (mlo_reg[0] ? {1'b0, mcand_reg} : 65'd0);
    assign prod  = {mhi_reg, mlo_reg};
    assign p64   = mneg_reg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
    assign psh64 = {{FRAC{p64[63]}}, p64[63:FRAC]};
    assign t64   = {{FRAC{t_reg[NUM_W-1]}}, t_reg};

    // Radicand: the weighted square is floor(|sigma| * x^2 / 2^16), capped.
    always_comb
    begin
        mag = (prod[95:FRAC] > MAG_CAP) ? MAG_CAP[63:0] : prod[79:FRAC];
        if (!sigma_reg[DW-1])
            rad = r2_reg + mag;
        else if (mag >= r2_reg)
            rad = 64'd0;
        else
            rad = r2_reg - mag;
    end

    assign rem2     = {srem_reg[31:0], srad_reg[63:62]};
    assign trial    = {sroot_reg, 2'b01};
    assign dtr      = {drem_reg[DW-2:0], dq_reg[NUM_W-1]};
    assign root_sat = (sroot_reg > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : sroot_reg;
    assign sin_q    = qsat(dq_reg, dneg_reg);

    always_comb
    begin
        tbl_we   = 1'b0;
        tbl_addr = row_reg;
        tbl_cos  = cosv_reg;
        tbl_sin  = sin_q;
        if (accept && !failed_reg && (sigma_reg != 0) && is_diagonal && (x_now == 0))
        begin
            tbl_we   = 1'b1;
            tbl_addr = row_index;
            tbl_cos  = ONE_Q;
            tbl_sin  = '0;
        end
        else if ((state_reg == S_DIV_DONE) && dsel_reg)
        begin
            tbl_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            cos_mem[tbl_addr] <= tbl_cos;
            sin_mem[tbl_addr] <= tbl_sin;
        end
        if (accept)
        begin
            c_reg <= cos_mem[row_index];
            s_reg <= sin_mem[row_index];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_SX;
            cnt_reg       <= '0;
            sigma_reg     <= ONE_Q;
            running_x_reg <= '0;
            failed_reg    <= 1'b0;
            fcol_reg      <= '0;
            ccount_reg    <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                sigma_reg <= cfg_wdata;
            if (ovalid_reg && !out_stall && (state_reg != S_DONE))
                ovalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        r_reg    <= r_value;
                        row_reg  <= row_index;
                        diag_reg <= is_diagonal;
                        last_reg <= last_column;
                        res_reg  <= r_value;
                        if (row_index == 4'd0)
                            running_x_reg <= x_value;
                        if (failed_reg || (sigma_reg == 0))
                            state_reg <= S_DONE;
                        else if (!is_diagonal)
                        begin
                            op_reg    <= OP_SX;
                            state_reg <= S_MUL_LOAD;
                        end
                        else if (x_now == 0)
                            state_reg <= S_DONE;
                        else
                        begin
                            op_reg    <= OP_RR;
                            state_reg <= S_MUL_LOAD;
                        end
                    end
                end
                S_MUL_LOAD:
                begin
                    mhi_reg <= '0;
                    cnt_reg <= '0;
                    if (op_reg == OP_XA)
                    begin
                        mcand_reg <= x2_reg;
                        mlo_reg   <= mag32(sigma_reg);
                        mneg_reg  <= 1'b0;
                    end
                    else
                    begin
                        mcand_reg <= {32'd0, mag32(mul_a)};
                        mlo_reg   <= mag32(mul_b);
                        mneg_reg  <= mul_a[DW-1] ^ mul_b[DW-1];
                    end
                    state_reg <= S_MUL_RUN;
                end
                S_MUL_RUN:
                begin
                    mhi_reg <= msum[64:1];
                    mlo_reg <= {msum[0], mlo_reg[31:1]};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == MUL_LAST)
                        state_reg <= S_MUL_DONE;
                end
                S_MUL_DONE:
                begin
                    unique case (op_reg)
                        OP_SX:
                        begin
                            sx_reg    <= sat64(psh64);
                            op_reg    <= OP_CR;
                            state_reg <= S_MUL_LOAD;
                        end
                        OP_CR:
                        begin
                            t_reg     <= psh64[NUM_W-1:0];
                            op_reg    <= OP_SG;
                            state_reg <= S_MUL_LOAD;
                        end
                        OP_SG:
                        begin
                            res_reg   <= sat64(t64 + psh64);
                            op_reg    <= OP_CX;
                            state_reg <= S_MUL_LOAD;
                        end
                        OP_CX:
                        begin
                            t_reg     <= psh64[NUM_W-1:0];
                            op_reg    <= OP_SR;
                            state_reg <= S_MUL_LOAD;
                        end
                        OP_SR:
                        begin
                            running_x_reg <= sat64(t64 - psh64);
                            state_reg     <= S_DONE;
                        end
                        OP_RR:
                        begin
                            r2_reg    <= prod[63:0];
                            op_reg    <= OP_XX;
                            state_reg <= S_MUL_LOAD;
                        end
                        OP_XX:
                        begin
                            x2_reg    <= prod[63:0];
                            op_reg    <= OP_XA;
                            state_reg <= S_MUL_LOAD;
                        end
                        default:
                        begin
                            if (rad == 64'd0)
                            begin
                                failed_reg <= 1'b1;
                                fcol_reg   <= (ccount_reg >= COL_MAX) ? COL_MAX
                                                                      : ccount_reg + 5'd1;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                srad_reg  <= rad;
                                srem_reg  <= '0;
                                sroot_reg <= '0;
                                cnt_reg   <= '0;
                                state_reg <= S_SQRT;
                            end
                        end
                    endcase
                end
                S_SQRT:
                begin
                    srad_reg <= {srad_reg[61:0], 2'b00};
                    if (rem2 >= trial)
                    begin
                        srem_reg  <= rem2 - trial;
                        sroot_reg <= {sroot_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg  <= rem2;
                        sroot_reg <= {sroot_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == SQRT_LAST)
                        state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    res_reg   <= root_sat;
                    dden_reg  <= root_sat;
                    dq_reg    <= {mag32(r_reg), 16'd0};
                    dneg_reg  <= r_reg[DW-1];
                    drem_reg  <= '0;
                    dsel_reg  <= 1'b0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV_RUN;
                end
                S_DIV_RUN:
                begin
                    if (dtr >= dden_reg)
                    begin
                        drem_reg <= dtr - dden_reg;
                        dq_reg   <= {dq_reg[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dtr;
                        dq_reg   <= {dq_reg[NUM_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == DIV_LAST)
                        state_reg <= S_DIV_DONE;
                end
                S_DIV_DONE:
                begin
                    if (!dsel_reg)
                    begin
                        cosv_reg  <= sin_q;
                        dq_reg    <= {mag32(running_x_reg), 16'd0};
                        dneg_reg  <= running_x_reg[DW-1];
                        drem_reg  <= '0;
                        dsel_reg  <= 1'b1;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV_RUN;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        ovalid_reg <= 1'b1;
                        or_reg     <= res_reg;
                        orow_reg   <= row_reg;
                        ostat_reg  <= failed_reg;
                        ofcol_reg  <= failed_reg ? fcol_reg : 5'd0;
                        oend_reg   <= diag_reg && last_reg;
                        if (diag_reg && last_reg)
                        begin
                            running_x_reg <= '0;
                            failed_reg    <= 1'b0;
                            fcol_reg      <= '0;
                            ccount_reg    <= '0;
                        end
                        else if (diag_reg && (ccount_reg < COL_MAX))
                            ccount_reg <= ccount_reg + 5'd1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid     = ovalid_reg;
    assign r_out         = or_reg;
    assign row_out       = orow_reg;
    assign status        = ostat_reg;
    assign fail_column   = ofcol_reg;
    assign end_of_update = oend_reg;

    a_fail_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status || (fail_column == 5'd0)))
        else $error("fail column reported without failure status");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request taken while one is in work");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ccount_reg <= COL_MAX) && (fcol_reg <= COL_MAX))
        else $error("column counter out of range");

endmodule
`default_nettype wire
